[rtl/triangle_similarity_match_assert.svh]
// Assertion macros used by the triangle similarity match top level
`ifndef TRIANGLE_SIMILARITY_MATCH_ASSERT_SVH
`define TRIANGLE_SIMILARITY_MATCH_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TRSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TRSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/trsm_pkg.sv]
// Types and constants of the triangle similarity match block
package trsm_pkg;

  localparam int COORD_BITS    = 12;
  localparam int LEN_FRAC      = 8;
  localparam int D2W           = 2 * COORD_BITS + 1;
  localparam int LEN_W         = (D2W + 2 * LEN_FRAC + 1) / 2;
  localparam int FRAC_BITS_DEF = 16;
  localparam int TOL_W         = 20;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(655);
  localparam int IDX_W         = 2;
  localparam int MID_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  localparam logic [IDX_W-1:0] SIDE0 = 2'd0;
  localparam logic [IDX_W-1:0] SIDE1 = 2'd1;
  localparam logic [IDX_W-1:0] SIDE2 = 2'd2;
  localparam logic [IDX_W-1:0] SIDE_NONE = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] ref_x0;
    logic [COORD_BITS-1:0] ref_y0;
    logic [COORD_BITS-1:0] ref_x1;
    logic [COORD_BITS-1:0] ref_y1;
    logic [COORD_BITS-1:0] ref_x2;
    logic [COORD_BITS-1:0] ref_y2;
    logic [COORD_BITS-1:0] cand_x0;
    logic [COORD_BITS-1:0] cand_y0;
    logic [COORD_BITS-1:0] cand_x1;
    logic [COORD_BITS-1:0] cand_y1;
    logic [COORD_BITS-1:0] cand_x2;
    logic [COORD_BITS-1:0] cand_y2;
  } in_item_t;

  typedef struct packed {
    logic             is_similar;
    logic [IDX_W-1:0] match_first;
    logic [IDX_W-1:0] match_second;
    logic [IDX_W-1:0] match_third;
    logic             degenerate;
  } out_item_t;

  // squared side lengths and degenerate flag handed from front to back
  typedef struct packed {
    logic [2:0][D2W-1:0] ref_d2;
    logic [2:0][D2W-1:0] cand_d2;
    logic                degenerate;
  } mid_item_t;

endpackage

[rtl/triangle_similarity_match.sv]
// Top level of the triangle similarity match block
// Usage:
//   Input queue: drive in_item and raise in_push; a transfer happens on a
//   clock edge with in_push high and in_full low. One pair of triangles per
//   transfer, one transfer per cycle sustained while in_full stays low.
//   Result queue: while out_empty is low the oldest result sits on out_item;
//   raising out_pop takes it. Results leave in input order, one per pair.
//   Config: cfg_data carries ratio_tolerance (16 fraction bits); written on
//   an edge with cfg_valid and cfg_ready high. cfg_ready is always high.
//   Write it only while no pair is in flight.
// Pipeline:
//   An input transfer registers the squared lengths, then moves through the
//   hand-off queue, a square root pipeline of one stage per root bit, a
//   divider pipeline of one stage per quotient bit, a compare, a pick stage
//   and the result queue write.
//   Throughput is one pair per cycle while the result queue is not full.
// Reset: synchronous, active low; queues empty, tolerance back to 655.
// Stall: when the result queue fills the back pipeline freezes, the hand-off
//   queue then fills and in_full rises; nothing is dropped.
module triangle_similarity_match #(
  parameter int FRAC_BITS = trsm_pkg::FRAC_BITS_DEF,
  parameter int MID_DEPTH = trsm_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = trsm_pkg::OUT_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  trsm_pkg::in_item_t         in_item,
  output logic                       in_full,
  output logic                       out_empty,
  output trsm_pkg::out_item_t        out_item,
  input  logic                       out_pop,
  input  logic                       cfg_valid,
  input  logic [trsm_pkg::TOL_W-1:0] cfg_data,
  output logic                       cfg_ready
);
  import trsm_pkg::*;
  `include "triangle_similarity_match_assert.svh"

  logic [TOL_W-1:0] tol_r;
  logic             accept, front_valid, mid_full, mid_empty, mid_push, mid_pop;
  logic             out_full, back_en, res_valid;
  mid_item_t        front_item, mid_head;
  out_item_t        res_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  assign in_full  = front_valid && mid_full;
  assign accept   = in_push && !in_full;
  assign mid_push = front_valid && !mid_full;
  assign back_en  = !out_full;
  assign mid_pop  = back_en && !mid_empty;

  trsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .mid_taken (mid_push),
    .valid     (front_valid),
    .mid_item  (front_item)
  );

  trsm_fifo #(.WIDTH($bits(mid_item_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (mid_push),
    .wr_data (front_item),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_head),
    .empty   (mid_empty)
  );

  trsm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (back_en),
    .in_valid  (mid_pop),
    .in_item   (mid_head),
    .tol       (tol_r),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  trsm_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_valid && back_en),
    .wr_data (res_item),
    .full    (out_full),
    .pop     (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

  `TRSM_ASSERT_IMPLY(a_sim_not_degen, clk, rst_n, !out_empty && out_item.is_similar,
                     !out_item.degenerate, "similar result flagged degenerate")
  `TRSM_ASSERT_IMPLY(a_sim_distinct, clk, rst_n, !out_empty && out_item.is_similar,
                     out_item.match_first != out_item.match_second &&
                     out_item.match_first != out_item.match_third &&
                     out_item.match_second != out_item.match_third &&
                     out_item.match_third != SIDE_NONE, "bad correspondence")
  `TRSM_ASSERT_IMPLY(a_nomatch_zero, clk, rst_n, !out_empty && !out_item.is_similar,
                     out_item.match_first == SIDE0 && out_item.match_second == SIDE0 &&
                     out_item.match_third == SIDE0, "match fields set without match")
  `TRSM_ASSERT_NEXT(a_accept_held, clk, rst_n, accept, front_valid,
                    "accepted pair lost in front end")
endmodule

[rtl/trsm_fifo.sv]
// Small register queue used as the hand-off queue and the result queue
module trsm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end
endmodule

[rtl/trsm_front.sv]
// Front end: takes triangle pairs, forms squared side lengths, flags degenerate candidates
module trsm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  trsm_pkg::in_item_t in_item,
  input  logic               mid_taken,
  output logic               valid,
  output trsm_pkg::mid_item_t mid_item
);
  import trsm_pkg::*;

  logic      valid_r;
  mid_item_t item_r, item_nxt;

  function automatic logic [D2W-1:0] sq_len(input logic [COORD_BITS-1:0] xa,
                                            input logic [COORD_BITS-1:0] ya,
                                            input logic [COORD_BITS-1:0] xb,
                                            input logic [COORD_BITS-1:0] yb);
    logic [COORD_BITS-1:0]   dx, dy;
    logic [2*COORD_BITS-1:0] px, py;
    dx = (xa > xb) ? xa - xb : xb - xa;
    dy = (ya > yb) ? ya - yb : yb - ya;
    px = dx * dx;
    py = dy * dy;
    return D2W'(px) + D2W'(py);
  endfunction

  always_comb begin
    item_nxt.ref_d2[0]  = sq_len(in_item.ref_x1, in_item.ref_y1, in_item.ref_x2, in_item.ref_y2);
    item_nxt.ref_d2[1]  = sq_len(in_item.ref_x0, in_item.ref_y0, in_item.ref_x2, in_item.ref_y2);
    item_nxt.ref_d2[2]  = sq_len(in_item.ref_x0, in_item.ref_y0, in_item.ref_x1, in_item.ref_y1);
    item_nxt.cand_d2[0] = sq_len(in_item.cand_x1, in_item.cand_y1,
                                 in_item.cand_x2, in_item.cand_y2);
    item_nxt.cand_d2[1] = sq_len(in_item.cand_x0, in_item.cand_y0,
                                 in_item.cand_x2, in_item.cand_y2);
    item_nxt.cand_d2[2] = sq_len(in_item.cand_x0, in_item.cand_y0,
                                 in_item.cand_x1, in_item.cand_y1);
    item_nxt.degenerate = (item_nxt.cand_d2[0] == '0) || (item_nxt.cand_d2[1] == '0) ||
                          (item_nxt.cand_d2[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (mid_taken) begin
      valid_r <= 1'b0;
    end
  end

  assign valid    = valid_r;
  assign mid_item = item_r;
endmodule

[rtl/trsm_sqrt.sv]
// Pipelined integer square root, one root bit per stage
module trsm_sqrt #(
  parameter int RW = 21
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] radicand,
  output logic [RW-1:0]   root
);
  logic [RW+1:0]   rem_q [RW+1];
  logic [RW-1:0]   res_q [RW+1];
  logic [2*RW-1:0] rad_q [RW+1];

  assign rem_q[0] = '0;
  assign res_q[0] = '0;
  assign rad_q[0] = radicand;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW+1:0] cur, trial;
    logic          ge;
    always_comb begin
      cur   = {rem_q[s][RW-1:0], rad_q[s][2*RW-1:2*RW-2]};
      trial = {res_q[s], 2'b01};
      ge    = (cur >= trial);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s+1] <= ge ? cur - trial : cur;
        res_q[s+1] <= {res_q[s][RW-2:0], ge};
        rad_q[s+1] <= {rad_q[s][2*RW-3:0], 2'b00};
      end
    end
  end

  assign root = res_q[RW];
endmodule

[rtl/trsm_div.sv]
// Pipelined restoring divider, one quotient bit per stage
module trsm_div #(
  parameter int NW = 37,
  parameter int DW = 21
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);
  logic [DW-1:0] rem_q [NW+1];
  logic [DW-1:0] den_q [NW+1];
  logic [NW-1:0] num_q [NW+1];
  logic [NW-1:0] quo_q [NW+1];

  assign rem_q[0] = '0;
  assign den_q[0] = den;
  assign num_q[0] = num;
  assign quo_q[0] = '0;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] cur;
    logic        ge;
    always_comb begin
      cur = {rem_q[s], num_q[s][NW-1]};
      ge  = (cur >= {1'b0, den_q[s]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s+1] <= ge ? DW'(cur - {1'b0, den_q[s]}) : DW'(cur);
        den_q[s+1] <= den_q[s];
        num_q[s+1] <= {num_q[s][NW-2:0], 1'b0};
        quo_q[s+1] <= {quo_q[s][NW-2:0], ge};
      end
    end
  end

  assign quo = quo_q[NW];
endmodule

[rtl/trsm_back.sv]
// Back end: side lengths, nine side ratios, tolerance compare and correspondence pick
module trsm_back #(
  parameter int FRAC_BITS = trsm_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  trsm_pkg::mid_item_t        in_item,
  input  logic [trsm_pkg::TOL_W-1:0] tol,
  output logic                       res_valid,
  output trsm_pkg::out_item_t        res_item
);
  import trsm_pkg::*;

  localparam int NW   = LEN_W + FRAC_BITS;
  localparam int PIPE = LEN_W + NW;

  logic [LEN_W-1:0] ref_len [3];
  logic [LEN_W-1:0] cand_len [3];
  logic [NW-1:0]    ratio [3][3];
  logic             vld_r [PIPE];
  logic             deg_r [PIPE];

  for (genvar n = 0; n < 3; n++) begin : g_len
    trsm_sqrt #(.RW(LEN_W)) u_sqrt_ref (
      .clk      (clk),
      .en       (en),
      .radicand ((2*LEN_W)'({in_item.ref_d2[n], {(2*LEN_FRAC){1'b0}}})),
      .root     (ref_len[n])
    );
    trsm_sqrt #(.RW(LEN_W)) u_sqrt_cand (
      .clk      (clk),
      .en       (en),
      .radicand ((2*LEN_W)'({in_item.cand_d2[n], {(2*LEN_FRAC){1'b0}}})),
      .root     (cand_len[n])
    );
  end

  for (genvar a = 0; a < 3; a++) begin : g_row
    for (genvar b = 0; b < 3; b++) begin : g_col
      trsm_div #(.NW(NW), .DW(LEN_W)) u_div (
        .clk (clk),
        .en  (en),
        .num ({ref_len[a], {FRAC_BITS{1'b0}}}),
        .den (cand_len[b]),
        .quo (ratio[a][b])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < PIPE; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < PIPE; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r[0] <= in_item.degenerate;
      for (int s = 1; s < PIPE; s++) begin
        deg_r[s] <= deg_r[s-1];
      end
    end
  end

  function automatic logic close_enough(input logic [NW-1:0] x, input logic [NW-1:0] y,
                                        input logic [TOL_W-1:0] t);
    logic [NW-1:0] d;
    d = (x > y) ? x - y : y - x;
    return d < NW'(t);
  endfunction

  // compare stage
  logic [2:0][2:0] c0_r, c2_r;
  logic            cvld_r, cdeg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        for (int j = 0; j < 3; j++) begin
          c0_r[p][j] <= close_enough(ratio[0][p], ratio[1][j], tol);
          c2_r[p][j] <= close_enough(ratio[2][p], ratio[1][j], tol);
        end
      end
      cdeg_r <= deg_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r <= 1'b0;
    end else if (en) begin
      cvld_r <= vld_r[PIPE-1];
    end
  end

  // pick stage: first (i, j) in scan order, then the remaining side k
  logic [IDX_W-1:0] pi, pj, pk;
  logic             found;
  out_item_t        res_nxt, res_r;
  logic             res_vld_r;

  always_comb begin
    found = 1'b1;
    pi    = SIDE0;
    pj    = SIDE1;
    priority if (c0_r[0][1]) begin
      pi = SIDE0; pj = SIDE1;
    end else if (c0_r[0][2]) begin
      pi = SIDE0; pj = SIDE2;
    end else if (c0_r[1][0]) begin
      pi = SIDE1; pj = SIDE0;
    end else if (c0_r[1][2]) begin
      pi = SIDE1; pj = SIDE2;
    end else if (c0_r[2][0]) begin
      pi = SIDE2; pj = SIDE0;
    end else if (c0_r[2][1]) begin
      pi = SIDE2; pj = SIDE1;
    end else begin
      found = 1'b0;
    end
    pk = IDX_W'(SIDE_NONE - pi - pj);
    res_nxt = '0;
    if (cdeg_r) begin
      res_nxt.degenerate = 1'b1;
    end else if (found && c2_r[pk][pj]) begin
      res_nxt.is_similar   = 1'b1;
      res_nxt.match_first  = pi;
      res_nxt.match_second = pj;
      res_nxt.match_third  = pk;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (en) begin
      res_vld_r <= cvld_r;
    end
  end

  assign res_valid = res_vld_r;
  assign res_item  = res_r;
endmodule
